@@ rtl/bleenv_pkg.sv @@
// Shared types and constants for the BLE advertising environment sensor parser.
// Used by the parser, the output skid stage and the top level.
package bleenv_pkg;

    localparam logic [7:0]  TAG_SERVICE = 8'h16;
    localparam logic [15:0] UUID_RESET  = 16'h181A;
    localparam logic [7:0]  LEN_LONG    = 8'd15;
    localparam logic [7:0]  LEN_SHORT   = 8'd13;

    typedef enum logic [1:0]
    {
        PH_LEN  = 2'd0,
        PH_TAG  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef enum logic [1:0]
    {
        ST_VALID   = 2'd0,
        ST_BAD_LEN = 2'd1,
        ST_OVERRUN = 2'd2
    } status_t;

    typedef struct packed
    {
        status_t            status;
        logic               is_long_format;
        logic signed [19:0] temperature_centi;
        logic [15:0]        humidity_centi;
        logic [15:0]        battery_mv;
        logic [7:0]         battery_level;
        logic [7:0]         frame_count;
    } result_t;

endpackage

@@ rtl/bleenv_parser.sv @@
// Length-tag-value walker and service data decoder for one payload byte per transaction.
// Depends on bleenv_pkg; holds the UUID register and all parse state.
module bleenv_parser
    import bleenv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_fire,
    input  logic [7:0]  in_byte,
    input  logic        in_start,
    input  logic        in_end,
    output logic        res_valid,
    output result_t     res
);

    logic [15:0] uuid_cfg_reg;
    phase_t      phase_reg, phase_next, phase_cur;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  tag_reg, tag_next;
    logic [7:0]  uuid_lo_reg, uuid_lo_next;
    logic [7:0]  idx_reg, idx_next;
    logic [15:0] temp_reg, temp_next;
    logic [15:0] hum_reg, hum_next;
    logic [15:0] bat_reg, bat_next;
    logic [7:0]  pct_reg, pct_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic        aborted_reg, aborted_next, aborted_cur;

    logic        emit;
    logic        overrun;
    logic [7:0]  pos;
    logic [7:0]  plen;
    logic [7:0]  emit_len;
    logic [19:0] temp_ext;
    logic [15:0] hum_scaled;

    assign pos      = idx_reg - 8'd2;
    assign plen     = pos + left_reg;
    assign emit_len = idx_reg - 8'd1;

    always_comb
    begin
        phase_cur    = in_start ? PH_LEN : phase_reg;
        aborted_cur  = in_start ? 1'b0 : aborted_reg;
        phase_next   = phase_reg;
        aborted_next = aborted_reg;
        left_next    = left_reg;
        tag_next     = tag_reg;
        uuid_lo_next = uuid_lo_reg;
        idx_next     = idx_reg;
        temp_next    = temp_reg;
        hum_next     = hum_reg;
        bat_next     = bat_reg;
        pct_next     = pct_reg;
        cnt_next     = cnt_reg;
        emit         = 1'b0;
        overrun      = 1'b0;
        if (in_fire)
        begin
            phase_next   = phase_cur;
            aborted_next = aborted_cur;
            if (!aborted_cur)
            begin
                unique case (phase_cur)
                    PH_LEN:
                    begin
                        if (in_byte != 8'd0)
                        begin
                            left_next  = in_byte;
                            phase_next = PH_TAG;
                        end
                    end
                    PH_TAG:
                    begin
                        tag_next   = in_byte;
                        left_next  = left_reg - 8'd1;
                        idx_next   = 8'd0;
                        phase_next = (left_reg == 8'd1) ? PH_LEN : PH_BODY;
                    end
                    PH_BODY:
                    begin
                        if (tag_reg == TAG_SERVICE)
                        begin
                            if (idx_reg == 8'd0)
                            begin
                                uuid_lo_next = in_byte;
                            end
                            else if (idx_reg == 8'd1)
                            begin
                                if ({in_byte, uuid_lo_reg} != uuid_cfg_reg)
                                begin
                                    tag_next = 8'd0;
                                end
                            end
                            else if (plen == LEN_LONG)
                            begin
                                unique case (pos)
                                    8'd6:    temp_next = {temp_reg[15:8], in_byte};
                                    8'd7:    temp_next = {in_byte, temp_reg[7:0]};
                                    8'd8:    hum_next  = {hum_reg[15:8], in_byte};
                                    8'd9:    hum_next  = {in_byte, hum_reg[7:0]};
                                    8'd10:   bat_next  = {bat_reg[15:8], in_byte};
                                    8'd11:   bat_next  = {in_byte, bat_reg[7:0]};
                                    8'd12:   pct_next  = in_byte;
                                    8'd13:   cnt_next  = in_byte;
                                    default: ;
                                endcase
                            end
                            else if (plen == LEN_SHORT)
                            begin
                                unique case (pos)
                                    8'd6:    temp_next = {in_byte, temp_reg[7:0]};
                                    8'd7:    temp_next = {temp_reg[15:8], in_byte};
                                    8'd8:    hum_next  = {8'd0, in_byte};
                                    8'd9:    pct_next  = in_byte;
                                    8'd10:   bat_next  = {in_byte, bat_reg[7:0]};
                                    8'd11:   bat_next  = {bat_reg[15:8], in_byte};
                                    8'd12:   cnt_next  = in_byte;
                                    default: ;
                                endcase
                            end
                        end
                        left_next = left_reg - 8'd1;
                        if (left_reg == 8'd1)
                        begin
                            phase_next = PH_LEN;
                            emit       = (tag_next == TAG_SERVICE) && (idx_reg != 8'd0);
                        end
                        else
                        begin
                            idx_next = idx_reg + 8'd1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_LEN;
                    end
                endcase
                if (in_end)
                begin
                    overrun      = (phase_next != PH_LEN) && !emit;
                    phase_next   = PH_LEN;
                    aborted_next = 1'b1;
                end
            end
        end
    end

    assign temp_ext   = {{4{temp_next[15]}}, temp_next};
    assign hum_scaled = 16'({8'd0, hum_next[7:0]} * 16'd100);

    always_comb
    begin
        res_valid = emit || overrun;
        res       = '0;
        if (overrun)
        begin
            res.status = ST_OVERRUN;
        end
        else if (emit_len == LEN_LONG)
        begin
            res.status            = ST_VALID;
            res.is_long_format    = 1'b1;
            res.temperature_centi = temp_ext;
            res.humidity_centi    = hum_next;
            res.battery_mv        = bat_next;
            res.battery_level     = pct_next;
            res.frame_count       = cnt_next;
        end
        else if (emit_len == LEN_SHORT)
        begin
            res.status            = ST_VALID;
            res.is_long_format    = 1'b0;
            res.temperature_centi = (temp_ext <<< 3) + (temp_ext <<< 1);
            res.humidity_centi    = hum_scaled;
            res.battery_mv        = bat_next;
            res.battery_level     = pct_next;
            res.frame_count       = cnt_next;
        end
        else
        begin
            res.status = ST_BAD_LEN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uuid_cfg_reg <= UUID_RESET;
            phase_reg    <= PH_LEN;
            left_reg     <= '0;
            tag_reg      <= '0;
            uuid_lo_reg  <= '0;
            idx_reg      <= '0;
            temp_reg     <= '0;
            hum_reg      <= '0;
            bat_reg      <= '0;
            pct_reg      <= '0;
            cnt_reg      <= '0;
            aborted_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                uuid_cfg_reg <= cfg_wr_data;
            end
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            tag_reg     <= tag_next;
            uuid_lo_reg <= uuid_lo_next;
            idx_reg     <= idx_next;
            temp_reg    <= temp_next;
            hum_reg     <= hum_next;
            bat_reg     <= bat_next;
            pct_reg     <= pct_next;
            cnt_reg     <= cnt_next;
            aborted_reg <= aborted_next;
        end
    end

    a_body_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> left_reg != 8'd0)
        else $error("body phase with no bytes left");

    a_abort_holds: assert property (@(posedge clk) disable iff (!rst_n)
        aborted_reg && !(in_fire && in_start) |=> aborted_reg && phase_reg == PH_LEN)
        else $error("aborted packet resumed without start");

endmodule

@@ rtl/bleenv_out_skid.sv @@
// Result register with one skid entry behind it.
// Depends on bleenv_pkg for the result type.
module bleenv_out_skid
    import bleenv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    push_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign pop        = out_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop || !out_valid_reg)
        begin
            out_valid_next  = skid_valid_reg || push;
            out_data_next   = skid_valid_reg ? skid_data_reg : push_data;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_ready |=> out_valid_reg && !skid_valid_reg)
        else $error("skid entry not moved on pop");

endmodule

@@ rtl/ble_adv_env_sensor_parser_top.sv @@
// A result for the byte that ends it is registered in the output register, or in the skid entry if that is held.
// Throughput: one byte per cycle while s_tready is high; the parser updates all state in the accept cycle.
// The skid stage keeps s_tready high until a second result is waiting behind the first.
// Reset: asynchronous, active low; parsing starts at a length byte, UUID reg is 0x181A.
// Top level of the BLE advertising environment sensor parser.
// Depends on bleenv_pkg, bleenv_parser and bleenv_out_skid.
module ble_adv_env_sensor_parser_top
    import bleenv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] packet_start
    input  logic        s_tlast,   // packet_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [19:0] temperature_centi, [35:20] humidity_centi,
                                   // [51:36] battery_mv, [59:52] battery_level,
                                   // [67:60] frame_count, [71:68] zero
    output logic [2:0]  m_tuser    // [1:0] status, [2] is_long_format
);

    logic    in_fire;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign in_fire = s_tvalid && s_tready;

    bleenv_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_fire     (in_fire),
        .in_byte     (s_tdata),
        .in_start    (s_tuser),
        .in_end      (s_tlast),
        .res_valid   (res_valid),
        .res         (res)
    );

    bleenv_out_skid u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_fire && res_valid),
        .push_data  (res),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_res)
    );

    assign m_tdata = {4'd0, out_res.frame_count, out_res.battery_level, out_res.battery_mv,
                      out_res.humidity_centi, out_res.temperature_centi};
    assign m_tuser = {out_res.is_long_format, out_res.status};

endmodule

@@ tb/ble_adv_env_sensor_parser_top_tb.sv @@
// Self-checking testbench for ble_adv_env_sensor_parser_top: streams advertising payload bytes,
// predicts the decoded sensor readings and error results, and compares each output transaction.
// Depends on bleenv_pkg and the parser RTL; needs no files or arguments.
module ble_adv_env_sensor_parser_top_tb;
    import bleenv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_BYTES = 240;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int DIRECTED_ROWS = 26;

    typedef struct packed
    {
        logic [7:0] data;
        logic       pkt_first;
        logic       pkt_end;
        logic       typed;
        status_t    code;
    } dir_row_t;

    localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'h00, 1'b1, 1'b0, 1'b0, ST_VALID},
        '{8'h04, 1'b0, 1'b0, 1'b0, ST_VALID},
        '{8'h16, 1'b0, 1'b0, 1'b0, ST_VALID},
        '{8'h1A, 1'b0, 1'b0, 1'b0, ST_VALID},
        '{8'h18, 1'b0, 1'b0, 1'b0, ST_VALID},
        '{8'hFF, 1'b0, 1'b0, 1'b1, ST_BAD_LEN},
        '{8'h02, 1'b0, 1'b0, 1'b0, ST_VALID},
        '{8'h16, 1'b0, 1'b0, 1'b0, ST_VALID},
        '{8'h1A, 1'b0, 1'b0, 1'b0, ST_VALID},
        '{8'h03, 1'b0, 1'b0, 1'b0, ST_VALID},
        '{8'h16, 1'b0, 1'b0, 1'b0, ST_VALID},
        '{8'h00, 1'b0, 1'b0, 1'b0, ST_VALID},
        '{8'h00, 1'b0, 1'b0, 1'b0, ST_VALID},
        '{8'h05, 1'b0, 1'b0, 1'b0, ST_VALID},
        '{8'h16, 1'b0, 1'b0, 1'b0, ST_VALID},
        '{8'h03, 1'b1, 1'b0, 1'b0, ST_VALID},
        '{8'h16, 1'b0, 1'b0, 1'b0, ST_VALID},
        '{8'h1A, 1'b0, 1'b0, 1'b0, ST_VALID},
        '{8'h18, 1'b0, 1'b0, 1'b1, ST_BAD_LEN},
        '{8'h09, 1'b0, 1'b1, 1'b1, ST_OVERRUN},
        '{8'h02, 1'b0, 1'b0, 1'b0, ST_VALID},
        '{8'hFF, 1'b1, 1'b1, 1'b1, ST_OVERRUN},
        '{8'h80, 1'b0, 1'b0, 1'b0, ST_VALID},
        '{8'h02, 1'b1, 1'b0, 1'b0, ST_VALID},
        '{8'h01, 1'b0, 1'b0, 1'b0, ST_VALID},
        '{8'h55, 1'b0, 1'b1, 1'b0, ST_VALID}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;

    ble_adv_env_sensor_parser_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #1 clk = ~clk;

    // Parser state mirror
    logic [15:0] uuid_setting = UUID_RESET;
    phase_t      parse_phase = PH_LEN;
    logic [7:0]  bytes_left = '0;
    logic [7:0]  cur_tag = '0;
    logic [7:0]  uuid_lo = '0;
    logic [7:0]  body_idx = '0;
    logic [15:0] raw_temp = '0;
    logic [15:0] raw_hum = '0;
    logic [15:0] raw_batt = '0;
    logic [7:0]  raw_pct = '0;
    logic [7:0]  raw_cnt = '0;
    logic        aborted = 1'b0;

    result_t     readings_due[$];
    logic [7:0]  pkt_bytes[$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_request = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;

    function automatic void stash_payload(input logic [7:0] pos, input logic [7:0] plen,
                                          input logic [7:0] v);
        if (plen == LEN_LONG)
        begin
            case (pos)
                8'd6:  raw_temp[7:0] = v;
                8'd7:  raw_temp[15:8] = v;
                8'd8:  raw_hum[7:0] = v;
                8'd9:  raw_hum[15:8] = v;
                8'd10: raw_batt[7:0] = v;
                8'd11: raw_batt[15:8] = v;
                8'd12: raw_pct = v;
                8'd13: raw_cnt = v;
                default: ;
            endcase
        end
        else if (plen == LEN_SHORT)
        begin
            case (pos)
                8'd6:  raw_temp[15:8] = v;
                8'd7:  raw_temp[7:0] = v;
                8'd8:  raw_hum = {8'h00, v};
                8'd9:  raw_pct = v;
                8'd10: raw_batt[15:8] = v;
                8'd11: raw_batt[7:0] = v;
                8'd12: raw_cnt = v;
                default: ;
            endcase
        end
    endfunction

    function automatic result_t make_reading(input logic [7:0] plen);
        result_t            r;
        logic signed [19:0] t;
        r = '0;
        t = {{4{raw_temp[15]}}, raw_temp};
        if (plen == LEN_LONG || plen == LEN_SHORT)
        begin
            r.status = ST_VALID;
            r.battery_mv = raw_batt;
            r.battery_level = raw_pct;
            r.frame_count = raw_cnt;
            if (plen == LEN_LONG)
            begin
                r.is_long_format = 1'b1;
                r.temperature_centi = t;
                r.humidity_centi = raw_hum;
            end
            else
            begin
                r.temperature_centi = 20'(t * 10);
                r.humidity_centi = 16'(raw_hum[7:0] * 100);
            end
        end
        else
        begin
            r.status = ST_BAD_LEN;
        end
        return r;
    endfunction

    function automatic bit decode_adv_byte(input logic [7:0] v, input logic pkt_first,
                                           input logic pkt_end, output result_t r);
        logic [7:0] b;
        logic [7:0] pos;
        bit         got;
        got = 1'b0;
        r = '0;
        if (pkt_first)
        begin
            parse_phase = PH_LEN;
            aborted = 1'b0;
        end
        if (aborted)
            return 1'b0;
        case (parse_phase)
            PH_LEN:
            begin
                if (v != 8'h00)
                begin
                    bytes_left = v;
                    parse_phase = PH_TAG;
                end
            end
            PH_TAG:
            begin
                cur_tag = v;
                bytes_left = bytes_left - 8'd1;
                body_idx = '0;
                parse_phase = (bytes_left == 8'd0) ? PH_LEN : PH_BODY;
            end
            default:
            begin
                b = body_idx;
                if (cur_tag == TAG_SERVICE)
                begin
                    if (b == 8'd0)
                        uuid_lo = v;
                    else if (b == 8'd1)
                    begin
                        if ({v, uuid_lo} != uuid_setting)
                            cur_tag = 8'h00;
                    end
                    else
                    begin
                        pos = b - 8'd2;
                        stash_payload(pos, pos + bytes_left, v);
                    end
                end
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'd0)
                begin
                    if (cur_tag == TAG_SERVICE && b >= 8'd1)
                    begin
                        r = make_reading(b - 8'd1);
                        got = 1'b1;
                    end
                    parse_phase = PH_LEN;
                end
                else
                begin
                    body_idx = b + 8'd1;
                end
            end
        endcase
        if (pkt_end)
        begin
            if (parse_phase != PH_LEN && !got)
            begin
                r = '0;
                r.status = ST_OVERRUN;
                got = 1'b1;
            end
            parse_phase = PH_LEN;
            aborted = 1'b1;
        end
        return got;
    endfunction

    task automatic send_byte(input logic [7:0] v, input logic pkt_first, input logic pkt_end);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        s_tuser <= pkt_first;
        s_tlast <= pkt_end;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic feed_byte(input logic [7:0] v, input logic pkt_first, input logic pkt_end);
        result_t r;
        send_byte(v, pkt_first, pkt_end);
        if (decode_adv_byte(v, pkt_first, pkt_end, r))
            readings_due.push_back(r);
    endtask

    task automatic drain_readings();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_uuid(input logic [15:0] value);
        drain_readings();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        uuid_setting = value;
    endtask

    function automatic logic [7:0] payload_byte();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return 8'h00;
        if (sel == 1)
            return 8'hFF;
        if (sel == 2)
            return 8'h80;
        return 8'($urandom_range(255));
    endfunction

    function automatic void add_service(input logic [15:0] uuid, input int plen);
        pkt_bytes.push_back(8'(plen + 3));
        pkt_bytes.push_back(TAG_SERVICE);
        pkt_bytes.push_back(uuid[7:0]);
        pkt_bytes.push_back(uuid[15:8]);
        repeat (plen) pkt_bytes.push_back(payload_byte());
    endfunction

    function automatic void build_packet();
        int          kind;
        int          plen;
        logic [15:0] other_uuid;
        logic [7:0]  other_tag;
        pkt_bytes.delete();
        repeat ($urandom_range(3, 1))
        begin
            kind = $urandom_range(99);
            if (kind < 30)
                add_service(uuid_setting, LEN_LONG);
            else if (kind < 55)
                add_service(uuid_setting, LEN_SHORT);
            else if (kind < 65)
            begin
                plen = $urandom_range(20);
                if (plen == LEN_LONG || plen == LEN_SHORT)
                    plen = 0;
                add_service(uuid_setting, plen);
            end
            else if (kind < 75)
            begin
                other_uuid = 16'($urandom_range(65535));
                if (other_uuid == uuid_setting)
                    other_uuid = ~other_uuid;
                add_service(other_uuid, $urandom_range(15));
            end
            else if (kind < 85)
            begin
                other_tag = 8'($urandom_range(255));
                if (other_tag == TAG_SERVICE)
                    other_tag = 8'h09;
                plen = $urandom_range(12, 1);
                pkt_bytes.push_back(8'(plen));
                pkt_bytes.push_back(other_tag);
                repeat (plen - 1) pkt_bytes.push_back(payload_byte());
            end
            else if (kind < 92)
            begin
                pkt_bytes.push_back(8'h00);
            end
            else
            begin
                plen = $urandom_range(2, 1);
                pkt_bytes.push_back(8'(plen));
                pkt_bytes.push_back(TAG_SERVICE);
                if (plen == 2)
                    pkt_bytes.push_back(uuid_setting[7:0]);
            end
        end
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Output side: random backpressure plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_request && !hold_done)
        begin
            m_tready <= 1'b0;
            hold_left <= HOLD_OFF_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : reading_check
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (readings_due.size() == 0)
            begin
                $error("unexpected reading, status %0d", m_tuser[1:0]);
                mismatch_count++;
            end
            else
            begin
                want = readings_due.pop_front();
                compare_field("status", want.status, m_tuser[1:0]);
                compare_field("is_long_format", want.is_long_format, m_tuser[2]);
                compare_field("temperature_centi", int'($signed(want.temperature_centi)),
                              int'($signed(m_tdata[19:0])));
                compare_field("humidity_centi", want.humidity_centi, m_tdata[35:20]);
                compare_field("battery_mv", want.battery_mv, m_tdata[51:36]);
                compare_field("battery_level", want.battery_level, m_tdata[59:52]);
                compare_field("frame_count", want.frame_count, m_tdata[67:60]);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        result_t     r;
        result_t     err_r;
        bit          got;
        int          phase_items;
        int          kind;
        bit          no_end;
        logic [15:0] cfg_plan [5];

        cfg_plan = '{UUID_RESET, 16'hFFFF, 16'h0000, 16'($urandom_range(65535)), UUID_RESET};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
        begin
            send_byte(DIRECTED[i].data, DIRECTED[i].pkt_first, DIRECTED[i].pkt_end);
            got = decode_adv_byte(DIRECTED[i].data, DIRECTED[i].pkt_first,
                                  DIRECTED[i].pkt_end, r);
            if (DIRECTED[i].typed)
            begin
                err_r = '0;
                err_r.status = DIRECTED[i].code;
                readings_due.push_back(err_r);
            end
            else if (got)
            begin
                readings_due.push_back(r);
            end
        end

        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph > 0)
                write_uuid(cfg_plan[ph]);
            case (ph)
                1: begin send_idle_pct = 69; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 69; end
                3: begin send_idle_pct = 8; recv_stall_pct = 8; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 4)
                hold_request = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_BYTES)
            begin
                if ($urandom_range(99) < 10)
                begin
                    pkt_bytes.delete();
                    repeat ($urandom_range(24, 1)) pkt_bytes.push_back(8'($urandom_range(255)));
                end
                else
                begin
                    build_packet();
                end
                kind = $urandom_range(99);
                // truncate so a structure runs past the packet end
                if (kind < 8 && pkt_bytes.size() > 1)
                    repeat ($urandom_range(pkt_bytes.size() - 1, 1)) void'(pkt_bytes.pop_back());
                no_end = (kind >= 8 && kind < 16);
                foreach (pkt_bytes[i])
                begin
                    feed_byte(pkt_bytes[i], i == 0, (i == pkt_bytes.size() - 1) && !no_end);
                    phase_items++;
                end
                if ($urandom_range(99) < 15)
                    repeat ($urandom_range(3, 1)) feed_byte(8'($urandom_range(255)), 1'b0, 1'b0);
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && readings_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
